// ===== rtl/core/tfrl_pkg.sv =====
package tfrl_pkg;

  // field widths
  localparam int unsigned SecW    = 32;
  localparam int unsigned UsecW   = 20;
  localparam int unsigned NowW    = 53;
  localparam int unsigned GapW    = 40;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned WindowW = 16;
  localparam int unsigned CountW  = 9;
  localparam int unsigned VerdictW = 2;
  localparam int unsigned CfgIdxW  = 2;

  // widest register sets the write data width
  localparam int unsigned CfgDataW = GapW;

  localparam logic [UsecW-1:0]   USEC_PER_SEC  = 20'd1000000;
  localparam logic [CountW-1:0]  COUNT_MAX     = 9'd511;
  localparam logic [GapW-1:0]    RST_MIN_GAP   = 40'd100000;
  localparam logic [LimitW-1:0]  RST_LIMIT     = 8'd5;
  localparam logic [WindowW-1:0] RST_WINDOW    = 16'd5;

  // register indexes
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW  = 2'd2;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_FIRE       = 2'd0,
    VERDICT_TOO_FAST   = 2'd1,
    VERDICT_FIRST_OVER = 2'd2,
    VERDICT_OVER       = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [GapW-1:0]    min_gap;
    logic [LimitW-1:0]  limit;
    logic [WindowW-1:0] window;
  } tfrl_cfg_t;

endpackage

// ===== rtl/core/tfrl_stamp.sv =====
module tfrl_stamp (
  input  logic [tfrl_pkg::SecW-1:0]  sec_i,
  input  logic [tfrl_pkg::UsecW-1:0] usec_i,
  output logic [tfrl_pkg::NowW-1:0]  now_o
);
  import tfrl_pkg::*;

  logic [SecW+UsecW-1:0] prod;

  // seconds to microseconds, then add the fractional part
  assign prod  = {{UsecW{1'b0}}, sec_i} * {{SecW{1'b0}}, USEC_PER_SEC};
  assign now_o = NowW'(prod) + NowW'(usec_i);

endmodule

// ===== rtl/core/tfrl_judge.sv =====
module tfrl_judge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tfrl_pkg::tfrl_cfg_t       cfg_i,
  input  logic                      fire_i,
  input  logic [tfrl_pkg::NowW-1:0] now_i,
  input  logic [tfrl_pkg::SecW-1:0] sec_i,
  output tfrl_pkg::verdict_e        verdict_o
);
  import tfrl_pkg::*;

  logic [NowW-1:0]   last_q, last_d;
  logic [SecW-1:0]   win_start_q, win_start_d;
  logic [CountW-1:0] count_q, count_d;

  logic            gap_en;
  logic            limit_en;
  logic [NowW:0]   gap;
  logic            too_fast;
  logic [SecW:0]   elapsed;
  logic            expired;
  logic [SecW-1:0] ws_open;
  logic [CountW-1:0] count_base;
  logic [CountW-1:0] count_inc;
  logic [CountW-1:0] limit_ext;

  assign gap_en   = (cfg_i.min_gap != '0);
  assign limit_en = (cfg_i.limit != '0);

  // signed gap, time going backwards counts as too fast
  assign gap      = {1'b0, now_i} - {1'b0, last_q};
  assign too_fast = gap_en &&
                    ($signed(gap) <= $signed({{(NowW+1-GapW){1'b0}}, cfg_i.min_gap}));

  assign elapsed = {1'b0, sec_i} - {1'b0, win_start_q};
  assign expired = $signed(elapsed) >= $signed({{(SecW+1-WindowW){1'b0}}, cfg_i.window});

  assign limit_ext = {{(CountW-LimitW){1'b0}}, cfg_i.limit};

  always_comb begin
    last_d      = gap_en ? now_i : last_q;
    win_start_d = win_start_q;
    count_d     = count_q;
    ws_open     = win_start_q;
    count_base  = count_q;
    count_inc   = count_q;
    verdict_o   = VERDICT_FIRE;
    if (too_fast) begin
      verdict_o = VERDICT_TOO_FAST;
    end else if (limit_en) begin
      // open the window, or close it once its length has passed
      if (win_start_q == '0) begin
        ws_open = sec_i;
      end else if (expired) begin
        ws_open    = '0;
        count_base = '0;
      end
      count_inc   = (count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
      count_d     = count_inc;
      win_start_d = ws_open;
      if (count_inc > limit_ext) begin
        if (count_inc == limit_ext + 1'b1) begin
          // first one over restarts the window
          win_start_d = sec_i;
          verdict_o   = VERDICT_FIRST_OVER;
        end else begin
          verdict_o = VERDICT_OVER;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      win_start_q <= '0;
      count_q     <= '0;
    end else if (fire_i) begin
      last_q      <= last_d;
      win_start_q <= win_start_d;
      count_q     <= count_d;
    end
  end

endmodule

// ===== rtl/core/trigger_fire_rate_limiter_unit.sv =====
// an input transfer passes the input capture, timestamp and verdict registers in order to reach the output
// throughput: one attempt per cycle, stalls only when the output is held back
// the only loop is the rate state in the decision stage, updated once per item
// reset (rst_ni low, asynchronous): pipeline empty, history and window cleared,
// registers back to min gap 100000 us, limit 5, window 5 s
module trigger_fire_rate_limiter_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tfrl_pkg::SecW-1:0]     stamp_sec_i,
  input  logic [tfrl_pkg::UsecW-1:0]    stamp_usec_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tfrl_pkg::VerdictW-1:0] verdict_o,
  input  logic                          cfg_we_i,
  input  logic [tfrl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tfrl_pkg::CfgDataW-1:0] cfg_data_i
);
  import tfrl_pkg::*;

  // configuration registers
  tfrl_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_gap <= RST_MIN_GAP;
      cfg_q.limit   <= RST_LIMIT;
      cfg_q.window  <= RST_WINDOW;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MIN_GAP: cfg_q.min_gap <= cfg_data_i[GapW-1:0];
        CFG_LIMIT:   cfg_q.limit   <= cfg_data_i[LimitW-1:0];
        CFG_WINDOW:  cfg_q.window  <= cfg_data_i[WindowW-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // three stages: input capture, timestamp in microseconds, verdict
  logic             s1_valid_q;
  logic [SecW-1:0]  s1_sec_q;
  logic [UsecW-1:0] s1_usec_q;
  logic             s2_valid_q;
  logic [SecW-1:0]  s2_sec_q;
  logic [NowW-1:0]  s2_now_q;
  logic             out_valid_q;
  verdict_e         verdict_q;

  logic             out_ready, s2_ready, s1_ready;
  logic [NowW-1:0]  s1_now;
  verdict_e         verdict_d;
  logic             fire;

  // a stage moves when it is empty or the next one moves
  assign out_ready = !out_valid_q || !out_stall_i;
  assign s2_ready  = !s2_valid_q || out_ready;
  assign s1_ready  = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // rate state advances exactly when a verdict is written to the output
  assign fire = s2_valid_q && out_ready;

  tfrl_stamp u_stamp (
    .sec_i  (s1_sec_q),
    .usec_i (s1_usec_q),
    .now_o  (s1_now)
  );

  tfrl_judge u_judge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .fire_i    (fire),
    .now_i     (s2_now_q),
    .sec_i     (s2_sec_q),
    .verdict_o (verdict_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (out_ready) out_valid_q <= s2_valid_q;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_sec_q  <= stamp_sec_i;
      s1_usec_q <= stamp_usec_i;
    end
    if (s1_valid_q && s2_ready) begin
      s2_sec_q <= s1_sec_q;
      s2_now_q <= s1_now;
    end
    if (fire) begin
      verdict_q <= verdict_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ===== rtl/core/tfrl_checker.sv =====
module tfrl_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tfrl_pkg::VerdictW-1:0] verdict_o
);

  // held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(verdict_o))
    else $error("output changed while stalled");

  // with the output empty the whole pipeline can move
  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // input is only held back by a held output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind trigger_fire_rate_limiter_unit tfrl_checker u_tfrl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .verdict_o   (verdict_o)
);

// ===== test/trigger_fire_rate_limiter_unit_test.sv =====
`timescale 1ns / 100ps

module trigger_fire_rate_limiter_unit_test;
  import tfrl_pkg::*;

  // index 3 decodes to no register, so writes to it must be ignored
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  localparam longint USEC_PER_S = 64'd1000000;
  // stamps are kept below 2^32 seconds
  localparam longint TIME_SPAN = 64'd4294967296 * 64'd1000000;
  localparam int unsigned COUNT_CEIL = 511;
  // longest quiet spell while work is outstanding: the input and output hold-offs
  // plus the pass through the pipeline, taken many times over
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [SecW-1:0]  sec;
    logic [UsecW-1:0] usec;
  } attempt_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [SecW-1:0]     stamp_sec_i = '0;
  logic [UsecW-1:0]    stamp_usec_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [VerdictW-1:0] verdict_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CFG_MIN_GAP;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  trigger_fire_rate_limiter_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .stamp_sec_i  (stamp_sec_i),
    .stamp_usec_i (stamp_usec_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .verdict_o    (verdict_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // register copies, starting from their reset values
  logic [GapW-1:0]    gap_cfg = RST_MIN_GAP;
  logic [LimitW-1:0]  limit_cfg = RST_LIMIT;
  logic [WindowW-1:0] window_cfg = RST_WINDOW;

  // limiter history as the block should hold it
  longint      last_attempt_us = 0;
  logic [31:0] window_open_sec = '0;
  int unsigned window_count = 0;

  attempt_t    pending_attempts[$];
  verdict_e    expected_verdicts[$];
  longint      stamp_clock_us = 0;   // time base the random attempts walk along

  bit          in_lazy = 1'b1;
  bit          out_lazy = 1'b1;
  bit          in_taken = 1'b0;
  bit          out_taken = 1'b0;
  int          in_wait = 0;
  int          out_wait = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned attempts_sent = 0;
  int unsigned verdicts_seen = 0;
  int unsigned settings_used = 1;
  int unsigned verdict_tally[4] = '{0, 0, 0, 0};

  // verdict for one attempt; advances the limiter history
  function automatic verdict_e judge_attempt(logic [SecW-1:0] sec, logic [UsecW-1:0] usec);
    longint   now_us;
    longint   gap_us;
    longint   elapsed;
    verdict_e verdict;
    verdict = VERDICT_FIRE;
    now_us = longint'({32'd0, sec}) * USEC_PER_S + longint'({44'd0, usec});
    // min gap: history only moves while the check is on
    if (gap_cfg != '0) begin
      gap_us = now_us - last_attempt_us;
      last_attempt_us = now_us;
      if (gap_us <= longint'({24'd0, gap_cfg})) return VERDICT_TOO_FAST;
    end
    if (limit_cfg != '0) begin
      // a start second of zero means no open window
      if (window_open_sec == '0) begin
        window_open_sec = sec;
      end else begin
        elapsed = longint'({32'd0, sec}) - longint'({32'd0, window_open_sec});
        if (elapsed >= longint'({48'd0, window_cfg})) begin
          window_count = 0;
          window_open_sec = '0;
        end
      end
      if (window_count < COUNT_CEIL) window_count++;
      if (window_count > limit_cfg) begin
        if (window_count == limit_cfg + 1) begin
          // first one over the limit restarts the window
          window_open_sec = sec;
          verdict = VERDICT_FIRST_OVER;
        end else begin
          verdict = VERDICT_OVER;
        end
      end
    end
    return verdict;
  endfunction

  function automatic int draw_wait(bit lazy);
    if (!lazy) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic longint rand_span();
    logic [63:0] r;
    r = {$urandom, $urandom};
    r[63] = 1'b0;
    return longint'(r);
  endfunction

  function automatic logic [GapW-1:0] rand_gap();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return GapW'($urandom_range(1, 2000000));
      2: return RST_MIN_GAP;
      default: return GapW'({$urandom, $urandom});
    endcase
  endfunction

  task automatic push_attempt(logic [SecW-1:0] sec, logic [UsecW-1:0] usec);
    pending_attempts.push_back('{sec: sec, usec: usec});
    stamp_clock_us = longint'({32'd0, sec}) * USEC_PER_S + longint'({44'd0, usec});
  endtask

  // next attempt along the time base, often around the gap and window edges;
  // dense mode keeps attempts close together so the count can saturate
  task automatic queue_attempt(bit dense);
    int unsigned pick;
    longint      gap_us;
    longint      step;
    longint      t;
    pick = $urandom_range(0, 99);
    gap_us = longint'({24'd0, gap_cfg});
    if (dense) begin
      step = longint'($urandom_range(0, 2000000));
    end else if (pick < 10) begin
      step = gap_us;                                   // right on the gap, too fast
    end else if (pick < 20) begin
      step = gap_us + 1;                               // just past the gap
    end else if (pick < 28) begin
      step = rand_span() % (gap_us + 1);
    end else if (pick < 58) begin
      step = gap_us + 1 + longint'($urandom_range(0, 3000000));
    end else if (pick < 74) begin
      // around the end of the counting window
      step = longint'({48'd0, window_cfg}) * USEC_PER_S
           + longint'($urandom_range(0, 2000000)) - 1000000;
      if (step <= gap_us) step = gap_us + 1 + longint'($urandom_range(0, 1000000));
    end else if (pick < 80) begin
      step = -longint'($urandom_range(0, 5000000));   // clock going backwards
    end else if (pick < 88) begin
      step = longint'($urandom_range(0, 100000000));
    end else if (pick < 94) begin
      // anywhere, microsecond part may run past a whole second
      push_attempt($urandom, UsecW'($urandom_range(0, 20'hFFFFF)));
      return;
    end else begin
      push_attempt('0, UsecW'($urandom_range(0, 999999)));
      return;
    end
    t = stamp_clock_us + step;
    if (t < 0) t = 0;
    t = t % TIME_SPAN;
    push_attempt(SecW'(t / USEC_PER_S), UsecW'(t % USEC_PER_S));
  endtask

  // wait at a falling edge until every attempt has its verdict
  task automatic drain();
    while (pending_attempts.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
      @(negedge clk_i);
  endtask

  // write all three registers back to back, now and then also the unused index
  task automatic load_setup(logic [GapW-1:0] gap, logic [LimitW-1:0] limit,
                            logic [WindowW-1:0] window);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_MIN_GAP;
    cfg_data_i <= gap;
    @(negedge clk_i);
    cfg_idx_i <= CFG_LIMIT;
    cfg_data_i <= CfgDataW'(limit);
    @(negedge clk_i);
    cfg_idx_i <= CFG_WINDOW;
    cfg_data_i <= CfgDataW'(window);
    @(negedge clk_i);
    if ($urandom_range(0, 1) == 0) begin
      cfg_idx_i <= CFG_UNUSED;
      cfg_data_i <= CfgDataW'({$urandom, $urandom});
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    gap_cfg = gap;
    limit_cfg = limit;
    window_cfg = window;
    settings_used++;
  endtask

  task automatic run_phase(logic [GapW-1:0] gap, logic [LimitW-1:0] limit,
                           logic [WindowW-1:0] window, int n, bit dense);
    drain();
    load_setup(gap, limit, window);
    in_lazy = $urandom_range(0, 3) != 0;
    out_lazy = $urandom_range(0, 3) != 0;
    repeat (n) queue_attempt(dense);
  endtask

  // input side: present the next pending attempt after a random hold-off
  always @(negedge clk_i) begin : attempt_driver
    logic     launch;
    attempt_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      launch = 1'b0;
      if (in_taken) begin
        in_taken = 1'b0;
        in_wait = draw_wait(in_lazy);
      end
      if (in_wait > 0) begin
        in_wait--;
      end else if (pending_attempts.size() > 0) begin
        nxt = pending_attempts.pop_front();
        stamp_sec_i <= nxt.sec;
        stamp_usec_i <= nxt.usec;
        launch = 1'b1;
      end
      in_valid_i <= launch;
    end
  end

  // output side: hold stall high for a random spell after each transfer
  always @(negedge clk_i) begin : verdict_sink
    if (rst_ni) begin
      if (out_taken) begin
        out_taken = 1'b0;
        out_wait = draw_wait(out_lazy);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // both transfers are seen at the rising edge; inputs are predicted first
  always @(posedge clk_i) begin : transfer_monitor
    verdict_e want;
    bit       moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (in_valid_i && !in_stall_o) begin
        want = judge_attempt(stamp_sec_i, stamp_usec_i);
        expected_verdicts.push_back(want);
        verdict_tally[want]++;
        attempts_sent++;
        in_taken = 1'b1;
        moved = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        out_taken = 1'b1;
        moved = 1'b1;
        verdicts_seen++;
        if (expected_verdicts.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: verdict %0d with no attempt waiting for it", $realtime, verdict_o);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_o !== want) begin
            if (mismatches < 10)
              $display("%0t: verdict mismatch, expected %0d (%s) got %0d",
                       $realtime, want, want.name(), verdict_o);
            mismatches++;
          end
        end
      end
      // only count silence while something is still owed
      if (moved)
        quiet_cycles = 0;
      else if (pending_attempts.size() != 0 || in_valid_i || expected_verdicts.size() != 0)
        quiet_cycles++;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(negedge clk_i);
    $display("no transfer for %0d cycles with work outstanding", QUIET_LIMIT);
    $display("trigger_fire_rate_limiter_unit_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed walk under the reset settings (gap 100000 us, limit 5, window 5 s)
    push_attempt(32'd0, 20'd0);              // stamped at zero right after reset: too fast
    push_attempt(32'd0, 20'd100001);         // second zero: counted, window stays shut
    push_attempt(32'd1, 20'd0);              // window opens at 1
    push_attempt(32'd1, 20'd100000);         // exactly the gap: too fast
    push_attempt(32'd1, 20'd200001);
    push_attempt(32'd1, 20'd400000);
    push_attempt(32'd1, 20'd600000);         // fifth in the window
    push_attempt(32'd1, 20'd800000);         // first over the limit
    push_attempt(32'd2, 20'd0);              // still over
    push_attempt(32'd7, 20'd0);              // window expired: count restarts, not reopened
    push_attempt(32'd7, 20'd500000);
    push_attempt(32'd3, 20'd0);              // time went backwards
    push_attempt(32'd8, 20'd0);
    push_attempt(32'd8, 20'd999999);
    push_attempt(32'hFFFF_FFFF, 20'hFFFFF);  // top of both fields, usec past a second
    push_attempt(32'd0, 20'd0);
    push_attempt(32'hFFFF_FFFF, 20'hFFFFF);

    // register extremes first, then random settings
    run_phase('0, 8'd3, 16'd2, 100, 1'b0);                   // gap check off
    run_phase(GapW'(1), 8'd1, 16'd0, 100, 1'b0);             // zero-length window
    run_phase({GapW{1'b1}}, 8'hFF, 16'hFFFF, 100, 1'b0);
    run_phase('0, '0, WindowW'($urandom), 100, 1'b0);        // both checks off
    run_phase(RST_MIN_GAP, '0, 16'd3, 100, 1'b0);
    run_phase('0, 8'hFF, 16'hFFFF, 520, 1'b1);               // drive the count into saturation
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 2))
        0: run_phase(rand_gap(), '0, WindowW'($urandom_range(0, 10)), 100, 1'b0);
        1: run_phase(rand_gap(), LimitW'($urandom_range(1, 8)),
                     WindowW'($urandom_range(0, 10)), 100, 1'b0);
        default: run_phase(rand_gap(), LimitW'($urandom), WindowW'($urandom), 100, 1'b0);
      endcase
    end

    drain();
    repeat (10) @(negedge clk_i);

    $display("%0d attempts and %0d verdicts over %0d register settings",
             attempts_sent, verdicts_seen, settings_used);
    $display("fire %0d, too fast %0d, first over %0d, over %0d, mismatches %0d",
             verdict_tally[VERDICT_FIRE], verdict_tally[VERDICT_TOO_FAST],
             verdict_tally[VERDICT_FIRST_OVER], verdict_tally[VERDICT_OVER], mismatches);
    if (mismatches == 0)
      $display("trigger_fire_rate_limiter_unit_test: PASS");
    else
      $display("trigger_fire_rate_limiter_unit_test: FAIL");
    $finish;
  end

endmodule
